[rtl/gsp_pkg.sv]
// Shared constants and field widths for the gshare predictor with target buffer.
`default_nettype none
package gsp_pkg;

  // default table geometry
  localparam int ADDR_BITS_DEF    = 10;
  localparam int HISTORY_BITS_DEF = 10;

  // fixed field widths of the words
  localparam int OP_W  = 2;
  localparam int PC_W  = 10;
  localparam int TGT_W = 10;
  localparam int CNT_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PREDICT = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

  // saturating counter levels
  localparam logic [CNT_W-1:0] CNT_MIN         = 2'd0;
  localparam logic [CNT_W-1:0] CNT_WEAK_TAKEN  = 2'd2;
  localparam logic [CNT_W-1:0] CNT_MAX         = 2'd3;

endpackage : gsp_pkg
`default_nettype wire

[rtl/gsp_if.sv]
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface gsp_in_if;
  import gsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PC_W-1:0]   pc;
  logic              actual_taken;
  logic [TGT_W-1:0]  target;

  modport source (output valid, output op, output pc, output actual_taken, output target,
                  input ready);
  modport sink   (input valid, input op, input pc, input actual_taken, input target,
                  output ready);
endinterface : gsp_in_if

interface gsp_out_if;
  import gsp_pkg::*;

  logic              valid;
  logic              ready;
  logic              btb_hit;
  logic              pred_taken;
  logic [TGT_W-1:0]  predicted_target;

  modport source (output valid, output btb_hit, output pred_taken,
                  output predicted_target, input ready);
  modport sink   (input valid, input btb_hit, input pred_taken,
                  input predicted_target, output ready);
endinterface : gsp_out_if
`default_nettype wire

[rtl/gsp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read old data on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : gsp_ram
`default_nettype wire

[rtl/gsp_clear.sv]
// Post-reset sweep that walks every table entry once to load reset values.
`default_nettype none
module gsp_clear #(
  parameter int ADDR_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  output logic                      busy,
  output logic      [ADDR_BITS-1:0] addr
);

  logic                 busy_r;
  logic [ADDR_BITS-1:0] addr_r;

  // advance one entry per cycle, drop busy after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else if (busy_r) begin
      addr_r <= addr_r + ADDR_BITS'(1);
      if (addr_r == {ADDR_BITS{1'b1}}) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign addr = addr_r;

endmodule : gsp_clear
`default_nettype wire

[rtl/gshare_predictor_with_btb_core.sv]
// Top level of the gshare direction predictor with branch target buffer.
// Usage:
//   in_chan carries one request word: op (predict, update, buffer write), pc,
//   actual_taken and target. out_chan returns exactly one result word per
//   request: btb_hit, pred_taken, predicted_target (all zero for any op
//   other than predict).
//   Each request reads the target buffer RAM and the counter RAM in the cycle
//   it is accepted; the result is formed and write-back done in the second
//   stage, and the result word is loaded into the output register as that
//   stage advances. A new request is taken every cycle while out_chan does
//   not stall; the read-modify-write loop through the RAMs is covered by
//   forwarding the last write of each RAM.
//   The global history shifts when an update is accepted, so the next request
//   already indexes with the new history.
//   After reset the block sweeps both RAMs, one entry a cycle, through all
//   2^ADDR_BITS entries (1024 by default), loading invalid buffer entries and
//   weakly taken counters; in_chan.ready stays low until the sweep ends.
//   When out_chan stalls, the output register holds its word, the request in
//   flight waits behind it, and in_chan.ready drops until room frees up.
`default_nettype none
module gshare_predictor_with_btb_core #(
  parameter int ADDR_BITS    = gsp_pkg::ADDR_BITS_DEF,
  parameter int HISTORY_BITS = gsp_pkg::HISTORY_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gsp_in_if.sink     in_chan,
  gsp_out_if.source  out_chan
);
  import gsp_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int TW    = (ADDR_BITS < TGT_W) ? ADDR_BITS : TGT_W;
  localparam int XW    = (ADDR_BITS > HISTORY_BITS) ? ADDR_BITS : HISTORY_BITS;
  localparam int BW    = TW + 1;

  // sweep control
  logic                 clr_busy;
  logic [ADDR_BITS-1:0] clr_addr;

  // accept side
  logic                    in_acc;
  logic [ADDR_BITS-1:0]    pc_a;
  logic [XW-1:0]           idx_x;
  logic [ADDR_BITS-1:0]    idx_a;
  logic [HISTORY_BITS-1:0] hist_r;

  // second stage
  logic                 s1_valid_r;
  logic [OP_W-1:0]      s1_op_r;
  logic                 s1_taken_r;
  logic [TW-1:0]        s1_tgt_r;
  logic [ADDR_BITS-1:0] s1_pc_r;
  logic [ADDR_BITS-1:0] s1_idx_r;
  logic                 s1_adv;

  // forwarding of the last write to each RAM
  logic                 fb_valid_r;
  logic [ADDR_BITS-1:0] fb_addr_r;
  logic [BW-1:0]        fb_data_r;
  logic                 fc_valid_r;
  logic [ADDR_BITS-1:0] fc_addr_r;
  logic [CNT_W-1:0]     fc_data_r;

  // RAM ports
  logic                 btb_we;
  logic [ADDR_BITS-1:0] btb_waddr;
  logic [BW-1:0]        btb_wdata;
  logic [BW-1:0]        btb_rdata;
  logic                 cnt_we;
  logic [ADDR_BITS-1:0] cnt_waddr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic [CNT_W-1:0]     cnt_rdata;

  // result formation
  logic [BW-1:0]    btb_cur;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_new;
  logic             res_hit;
  logic             res_taken;
  logic [TGT_W-1:0] res_tgt;
  logic             do_update;
  logic             do_write;

  // output register
  logic             out_valid_r;
  logic             out_hit_r;
  logic             out_taken_r;
  logic [TGT_W-1:0] out_tgt_r;

  gsp_clear #(.ADDR_BITS(ADDR_BITS)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  // handshake and index
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !clr_busy && (!s1_valid_r || s1_adv);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign pc_a          = ADDR_BITS'(in_chan.pc);
  assign idx_x         = XW'(hist_r) ^ XW'(pc_a);
  assign idx_a         = ADDR_BITS'(idx_x);

  // shift the outcome into the history at accept of an update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (in_acc && in_chan.op == OP_UPDATE) begin
      hist_r <= HISTORY_BITS'({hist_r, in_chan.actual_taken});
    end
  end

  // advance the request into the second stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_chan.op;
      s1_taken_r <= in_chan.actual_taken;
      s1_tgt_r   <= TW'(in_chan.target);
      s1_pc_r    <= pc_a;
      s1_idx_r   <= idx_a;
    end
  end

  // pick forwarded data where the last write hit the same entry
  assign btb_cur = (fb_valid_r && fb_addr_r == s1_pc_r)  ? fb_data_r : btb_rdata;
  assign cnt_cur = (fc_valid_r && fc_addr_r == s1_idx_r) ? fc_data_r : cnt_rdata;

  // saturating counter step
  always_comb begin
    priority if (s1_taken_r) begin
      cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
    end else begin
      cnt_new = (cnt_cur == CNT_MIN) ? cnt_cur : cnt_cur - CNT_W'(1);
    end
  end

  assign do_update = s1_adv && s1_op_r == OP_UPDATE;
  assign do_write  = s1_adv && s1_op_r == OP_WRITE;
  assign res_hit   = (s1_op_r == OP_PREDICT) && btb_cur[BW-1];
  assign res_taken = res_hit && (cnt_cur >= CNT_WEAK_TAKEN);
  assign res_tgt   = res_hit ? TGT_W'(btb_cur[TW-1:0]) : '0;

  // RAM write ports: sweep first, then write-back
  assign btb_we    = clr_busy || do_write;
  assign btb_waddr = clr_busy ? clr_addr : s1_pc_r;
  assign btb_wdata = clr_busy ? '0 : {1'b1, s1_tgt_r};
  assign cnt_we    = clr_busy || do_update;
  assign cnt_waddr = clr_busy ? clr_addr : s1_idx_r;
  assign cnt_wdata = clr_busy ? CNT_WEAK_TAKEN : cnt_new;

  gsp_ram #(.WIDTH(BW), .DEPTH(DEPTH)) u_btb_ram (
    .clk   (clk),
    .we    (btb_we),
    .waddr (btb_waddr),
    .wdata (btb_wdata),
    .re    (in_acc),
    .raddr (pc_a),
    .rdata (btb_rdata)
  );

  gsp_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (in_acc),
    .raddr (idx_a),
    .rdata (cnt_rdata)
  );

  // track the last write-back of each RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_valid_r <= 1'b0;
      fc_valid_r <= 1'b0;
    end else begin
      if (do_write) begin
        fb_valid_r <= 1'b1;
      end
      if (do_update) begin
        fc_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      fb_addr_r <= s1_pc_r;
      fb_data_r <= {1'b1, s1_tgt_r};
    end
    if (do_update) begin
      fc_addr_r <= s1_idx_r;
      fc_data_r <= cnt_new;
    end
  end

  // output register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit_r   <= res_hit;
      out_taken_r <= res_taken;
      out_tgt_r   <= res_tgt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.btb_hit          = out_hit_r;
  assign out_chan.pred_taken       = out_taken_r;
  assign out_chan.predicted_target = out_tgt_r;

endmodule : gshare_predictor_with_btb_core
`default_nettype wire
